[rtl/core/wpp_pkg.sv]
// Shared types, constants and codes for the WAV PCM16 stream parser.
`timescale 1ns / 1ps

package wpp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 32;
  localparam int unsigned HalfW  = 16;
  localparam int unsigned IdxW   = 5;
  localparam int unsigned StatW  = 3;

  localparam logic [WordW-1:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [WordW-1:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [WordW-1:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [WordW-1:0] TAG_DATA = 32'h6461_7461;

  localparam logic [WordW-1:0] FMT_BODY_LEN = 32'd16;
  localparam logic [HalfW-1:0] PCM_FORMAT   = 16'd1;
  localparam logic [HalfW-1:0] PCM_BITS     = 16'd16;

  // Byte counts at which each field of the fmt body has fully arrived, and the length of a tag.
  localparam logic [IdxW-1:0] FMT_IDX_FORMAT   = 5'd2;
  localparam logic [IdxW-1:0] FMT_IDX_CHANNELS = 5'd4;
  localparam logic [IdxW-1:0] FMT_IDX_RATE     = 5'd8;
  localparam logic [IdxW-1:0] FMT_IDX_BITS     = 5'd16;
  localparam logic [IdxW-1:0] TAG_BYTES        = 5'd4;

  typedef enum logic [8:0] {
    PH_RIFF_TAG   = 9'b0_0000_0001,
    PH_RIFF_SIZE  = 9'b0_0000_0010,
    PH_WAVE_TAG   = 9'b0_0000_0100,
    PH_CHUNK_ID   = 9'b0_0000_1000,
    PH_CHUNK_SIZE = 9'b0_0001_0000,
    PH_FMT_BODY   = 9'b0_0010_0000,
    PH_SKIP       = 9'b0_0100_0000,
    PH_DATA       = 9'b0_1000_0000,
    PH_HALT       = 9'b1_0000_0000
  } phase_t;

  typedef enum logic [StatW-1:0] {
    ST_OK         = 3'd0,
    ST_NOT_RIFF   = 3'd1,
    ST_NOT_WAVE   = 3'd2,
    ST_BAD_FORMAT = 3'd3,
    ST_MISSING    = 3'd4
  } status_t;

  typedef struct packed {
    logic [ByteW-1:0] byte_in;
    logic             last_byte;
  } in_beat_t;

  typedef struct packed {
    logic                    sample_valid;
    logic signed [HalfW-1:0] sample_value;
    logic                    finished;
    status_t                 status;
    logic [HalfW-1:0]        channels;
    logic [WordW-1:0]        pcm_rate;
  } res_t;

endpackage

[rtl/core/wpp_in_if.sv]
// Byte input channel of the WAV PCM16 stream parser.
`timescale 1ns / 1ps

interface wpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

[rtl/core/wpp_out_if.sv]
// Result channel of the WAV PCM16 stream parser.
`timescale 1ns / 1ps

interface wpp_out_if;
  logic               valid;
  logic               ready;
  logic               sample_valid;
  logic signed [15:0] sample_value;
  logic               finished;
  logic [2:0]         status;
  logic [15:0]        channels;
  logic [31:0]        pcm_rate;

  modport source (output valid, output sample_valid, output sample_value, output finished,
                  output status, output channels, output pcm_rate, input ready);
  modport sink   (input valid, input sample_valid, input sample_value, input finished,
                  input status, input channels, input pcm_rate, output ready);
endinterface

[rtl/core/wpp_in_stage.sv]
// Input register stage: holds one accepted byte beat for the parser core.
`timescale 1ns / 1ps

module wpp_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  wpp_pkg::in_beat_t in_beat,
  output logic              beat_valid,
  output wpp_pkg::in_beat_t beat,
  input  logic              beat_take
);
  import wpp_pkg::*;

  logic     valid_r;
  in_beat_t beat_r;

  // The register refills in the same cycle that the core consumes it.
  assign in_ready   = !valid_r || beat_take;
  assign beat_valid = valid_r;
  assign beat       = beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      beat_r <= in_beat;
    end
  end

endmodule

[rtl/core/wpp_parser_core.sv]
// Parser state and the per-byte next-state logic of the RIFF WAVE walker.
`timescale 1ns / 1ps

module wpp_parser_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              beat_valid,
  input  wpp_pkg::in_beat_t beat,
  output logic              beat_take,
  output logic              res_valid,
  output wpp_pkg::res_t     res,
  input  logic              res_ready
);
  import wpp_pkg::*;

  phase_t            phase_r,   phase_nxt;
  logic [WordW-1:0]  rem_r,     rem_nxt;
  logic [WordW-1:0]  tag_r,     tag_nxt;
  logic [WordW-1:0]  fld_r,     fld_nxt;
  logic [IdxW-1:0]   idx_r,     idx_nxt;
  logic [ByteW-1:0]  hold_r,    hold_nxt;
  logic              present_r, present_nxt;
  logic              seen_fmt_r, seen_fmt_nxt;
  logic              seen_data_r, seen_data_nxt;
  logic [HalfW-1:0]  chan_r,    chan_nxt;
  logic [WordW-1:0]  rate_r,    rate_nxt;
  status_t           err_r,     err_nxt;

  logic [WordW-1:0]  tag_in;
  logic [WordW-1:0]  fld_in;
  logic [IdxW-1:0]   idx_inc;
  logic [WordW-1:0]  rem_dec;
  logic [WordW-1:0]  fmt_extra;
  logic              group_done;
  logic              made;
  logic [HalfW-1:0]  sample;
  logic              emit;
  status_t           fin_status;

  assign tag_in     = {tag_r[WordW-ByteW-1:0], beat.byte_in};
  assign fld_in     = {beat.byte_in, fld_r[WordW-1:ByteW]};
  assign idx_inc    = idx_r + 5'd1;
  assign group_done = (idx_inc[1:0] == 2'b00);
  assign rem_dec    = rem_r - 32'd1;
  assign fmt_extra  = (fld_in > FMT_BODY_LEN) ? (fld_in - FMT_BODY_LEN) : '0;

  always_comb begin
    phase_nxt     = phase_r;
    rem_nxt       = rem_r;
    tag_nxt       = tag_r;
    fld_nxt       = fld_r;
    idx_nxt       = idx_r;
    hold_nxt      = hold_r;
    present_nxt   = present_r;
    seen_fmt_nxt  = seen_fmt_r;
    seen_data_nxt = seen_data_r;
    chan_nxt      = chan_r;
    rate_nxt      = rate_r;
    err_nxt       = err_r;
    made          = 1'b0;
    sample        = '0;

    if (phase_r != PH_HALT) begin
      tag_nxt = tag_in;
      fld_nxt = fld_in;
      idx_nxt = idx_inc;
      case (phase_r)
        PH_RIFF_TAG: begin
          if (group_done) begin
            if (tag_in != TAG_RIFF) begin
              err_nxt   = ST_NOT_RIFF;
              phase_nxt = PH_HALT;
            end else begin
              phase_nxt = PH_RIFF_SIZE;
            end
          end
        end
        PH_RIFF_SIZE: begin
          if (group_done) begin
            phase_nxt = PH_WAVE_TAG;
          end
        end
        PH_WAVE_TAG: begin
          if (group_done) begin
            if (tag_in != TAG_WAVE) begin
              err_nxt   = ST_NOT_WAVE;
              phase_nxt = PH_HALT;
            end else begin
              phase_nxt = PH_CHUNK_ID;
              idx_nxt   = '0;
            end
          end
        end
        PH_CHUNK_ID: begin
          if (group_done) begin
            phase_nxt = PH_CHUNK_SIZE;
            // The chunk id is parked in the remaining-byte counter while the size arrives.
            if (idx_inc == TAG_BYTES) begin
              rem_nxt = tag_in;
              idx_nxt = '0;
            end
          end
        end
        PH_CHUNK_SIZE: begin
          if (group_done) begin
            tag_nxt = rem_r;
            idx_nxt = '0;
            if (rem_r == TAG_FMT) begin
              rem_nxt   = fmt_extra;
              phase_nxt = PH_FMT_BODY;
            end else if (rem_r == TAG_DATA) begin
              seen_data_nxt = 1'b1;
              rem_nxt       = fld_in;
              present_nxt   = 1'b0;
              phase_nxt     = (fld_in != '0) ? PH_DATA : PH_CHUNK_ID;
            end else begin
              rem_nxt   = fld_in;
              phase_nxt = (fld_in != '0) ? PH_SKIP : PH_CHUNK_ID;
            end
          end
        end
        PH_FMT_BODY: begin
          if (idx_inc == FMT_IDX_FORMAT) begin
            if (fld_in[WordW-1:HalfW] != PCM_FORMAT) begin
              err_nxt   = ST_BAD_FORMAT;
              phase_nxt = PH_HALT;
            end
          end else if (idx_inc == FMT_IDX_CHANNELS) begin
            chan_nxt = fld_in[WordW-1:HalfW];
          end else if (idx_inc == FMT_IDX_RATE) begin
            rate_nxt = fld_in;
          end else if (idx_inc == FMT_IDX_BITS) begin
            if (fld_in[WordW-1:HalfW] != PCM_BITS) begin
              err_nxt   = ST_BAD_FORMAT;
              phase_nxt = PH_HALT;
            end else begin
              seen_fmt_nxt = 1'b1;
              idx_nxt      = '0;
              phase_nxt    = (rem_r != '0) ? PH_SKIP : PH_CHUNK_ID;
            end
          end
        end
        PH_SKIP: begin
          rem_nxt = rem_dec;
          if (rem_dec == '0) begin
            idx_nxt   = '0;
            phase_nxt = PH_CHUNK_ID;
          end
        end
        PH_DATA: begin
          if (present_r) begin
            made        = 1'b1;
            sample      = {beat.byte_in, hold_r};
            present_nxt = 1'b0;
          end else begin
            hold_nxt    = beat.byte_in;
            present_nxt = 1'b1;
          end
          rem_nxt = rem_dec;
          // An unpaired byte at the end of the chunk is dropped.
          if (rem_dec == '0) begin
            present_nxt = 1'b0;
            idx_nxt     = '0;
            phase_nxt   = PH_CHUNK_ID;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Status as seen after this byte has been taken.
  always_comb begin
    if (err_nxt != ST_OK) begin
      fin_status = err_nxt;
    end else if (phase_nxt == PH_RIFF_TAG) begin
      fin_status = ST_NOT_RIFF;
    end else if (phase_nxt == PH_RIFF_SIZE || phase_nxt == PH_WAVE_TAG) begin
      fin_status = ST_NOT_WAVE;
    end else if (phase_nxt == PH_FMT_BODY) begin
      fin_status = ST_BAD_FORMAT;
    end else if (!seen_fmt_nxt || !seen_data_nxt) begin
      fin_status = ST_MISSING;
    end else begin
      fin_status = ST_OK;
    end
  end

  assign emit      = made || beat.last_byte;
  assign res_valid = beat_valid && emit;
  assign beat_take = beat_valid && (!emit || res_ready);

  always_comb begin
    res.sample_valid = made;
    res.sample_value = sample;
    res.finished     = beat.last_byte;
    res.status       = beat.last_byte ? fin_status : ST_OK;
    res.channels     = '0;
    res.pcm_rate     = '0;
    if (beat.last_byte && fin_status == ST_OK) begin
      res.channels = chan_nxt;
      res.pcm_rate = rate_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (beat_take && beat.last_byte)) begin
      phase_r     <= PH_RIFF_TAG;
      rem_r       <= '0;
      tag_r       <= '0;
      fld_r       <= '0;
      idx_r       <= '0;
      hold_r      <= '0;
      present_r   <= 1'b0;
      seen_fmt_r  <= 1'b0;
      seen_data_r <= 1'b0;
      chan_r      <= '0;
      rate_r      <= '0;
      err_r       <= ST_OK;
    end else if (beat_take) begin
      phase_r     <= phase_nxt;
      rem_r       <= rem_nxt;
      tag_r       <= tag_nxt;
      fld_r       <= fld_nxt;
      idx_r       <= idx_nxt;
      hold_r      <= hold_nxt;
      present_r   <= present_nxt;
      seen_fmt_r  <= seen_fmt_nxt;
      seen_data_r <= seen_data_nxt;
      chan_r      <= chan_nxt;
      rate_r      <= rate_nxt;
      err_r       <= err_nxt;
    end
  end

endmodule

[rtl/core/wpp_out_stage.sv]
// Output register stage: holds one result beat until the sink takes it.
`timescale 1ns / 1ps

module wpp_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_valid,
  input  wpp_pkg::res_t res,
  output logic          res_ready,
  output logic          out_valid,
  output wpp_pkg::res_t out_res,
  input  logic          out_ready
);
  import wpp_pkg::*;

  logic valid_r;
  res_t res_r;

  assign res_ready = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      res_r <= res;
    end
  end

endmodule

[rtl/core/wav_pcm16_stream_parser.sv]
// Top level of the RIFF WAVE PCM16 byte-stream parser.
`timescale 1ns / 1ps

// Channel      Dir  Payload                                          Beat
// in_stream    in   byte_in[7:0], last_byte                          one file byte
// out_stream   out  sample_valid, sample_value[15:0] signed,         one sample and/or
//                   finished, status[2:0], channels[15:0],           the end-of-file
//                   pcm_rate[31:0]                                   status
//
// One byte is accepted per clock cycle while no byte that yields a result waits on a full
// result register; a byte's result reaches out_stream through the input register and then
// the result register. The parser core updates its whole chunk-walking state from each
// byte as it takes it. Reset is synchronous and active low; it returns the parser to the
// start of a file, as does the acceptance of a byte marked last. When the result register
// is full and not taken, a byte that yields a result waits in the input register, and
// in_stream.ready stays high only while that register can still be refilled.

module wav_pcm16_stream_parser (
  input logic      clk,
  input logic      rst_n,
  wpp_in_if.sink   in_stream,
  wpp_out_if.source out_stream
);
  import wpp_pkg::*;

  in_beat_t in_beat;
  in_beat_t beat;
  logic     beat_valid;
  logic     beat_take;
  res_t     res;
  logic     res_valid;
  logic     res_ready;
  res_t     out_res;

  // Bundle the incoming payload for the input register.
  assign in_beat.byte_in   = in_stream.byte_in;
  assign in_beat.last_byte = in_stream.last_byte;

  wpp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_stream.valid),
    .in_ready   (in_stream.ready),
    .in_beat    (in_beat),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_take  (beat_take)
  );

  // The core consumes the held byte whenever its result, if any, can be registered.
  wpp_parser_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_take  (beat_take),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready)
  );

  wpp_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_stream.valid),
    .out_res   (out_res),
    .out_ready (out_stream.ready)
  );

  // Unpack the registered result onto the output channel.
  assign out_stream.sample_valid = out_res.sample_valid;
  assign out_stream.sample_value = out_res.sample_value;
  assign out_stream.finished     = out_res.finished;
  assign out_stream.status       = out_res.status;
  assign out_stream.channels     = out_res.channels;
  assign out_stream.pcm_rate     = out_res.pcm_rate;

endmodule
